// File: sv/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/npcm_pkg.sv
package npcm_pkg;

    // field widths
    localparam int CMD_W   = 1;
    localparam int EIDX_W  = 8;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int COUNT_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;
    localparam logic [DIST_W-1:0]  MAX_DIST    = 18'd195075;

    // item command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_entry;
        logic start_query;
        logic issue_read;
        logic load_result;
    } npcm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic result_done;
    } npcm_status_t;

endpackage

// File: sv/npcm_if.sv
// input item channel
interface npcm_in_if import npcm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [EIDX_W-1:0]  entry_index;
    logic [COLOR_W-1:0] entry_color;
    logic [COLOR_W-1:0] query_color;

    modport source (output valid, cmd, entry_index, entry_color, query_color, input ready);
    modport sink   (input valid, cmd, entry_index, entry_color, query_color, output ready);
endinterface

// result item channel
interface npcm_out_if import npcm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [EIDX_W-1:0] best_index;
    logic [DIST_W-1:0] best_distance;

    modport source (output valid, best_index, best_distance, input ready);
    modport sink   (input valid, best_index, best_distance, output ready);
endinterface

// File: sv/nearest_palette_color_match_unit.sv
// load item: written straight into the palette ram at the transfer
// query item: the scan reads one palette entry per cycle from the single ram read
// port, then a four-stage distance/minimum pipeline drains; next item is taken once
// the result is registered
// reset: async active low, clears control state and sets palette_count to one;
// palette contents are not cleared
module nearest_palette_color_match_unit import npcm_pkg::*; #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    npcm_in_if.sink            in_ch,
    npcm_out_if.source         out_ch,
    input  logic               palette_count_we,
    input  logic [COUNT_W-1:0] palette_count_wdata
);

    npcm_cmd_t    ctl;
    npcm_status_t sts;

    // sequencer
    npcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    // palette, distance pipeline and result register
    npcm_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .count_we      (palette_count_we),
        .count_wdata   (palette_count_wdata),
        .entry_index   (in_ch.entry_index),
        .entry_color   (in_ch.entry_color),
        .query_color   (in_ch.query_color),
        .best_index    (out_ch.best_index),
        .best_distance (out_ch.best_distance)
    );

endmodule

// File: sv/npcm_ram.sv
module npcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/npcm_ctrl.sv
module npcm_ctrl import npcm_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [CMD_W-1:0] in_cmd,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output npcm_cmd_t    ctl,
    input  npcm_status_t sts
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer;

    // state and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ctl             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_cmd == CMD_QUERY)
                    begin
                        ctl.start_query = 1'b1;
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        ctl.load_entry = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl.issue_read = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.result_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/npcm_dp.sv
module npcm_dp import npcm_pkg::*; #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  npcm_cmd_t          ctl,
    output npcm_status_t       sts,
    input  logic               count_we,
    input  logic [COUNT_W-1:0] count_wdata,
    input  logic [EIDX_W-1:0]  entry_index,
    input  logic [COLOR_W-1:0] entry_color,
    input  logic [COLOR_W-1:0] query_color,
    output logic [EIDX_W-1:0]  best_index,
    output logic [DIST_W-1:0]  best_distance
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(PALETTE_DEPTH);

    function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    logic [COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [IDX_W-1:0]   addr_reg;
    logic [COLOR_W-1:0] query_reg;
    logic [COLOR_W-1:0] rd_data;
    logic               wr_en;

    // stage tags: s1 ram data, s2 squares, s3 distance
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic               s1_last_reg, s2_last_reg, s3_last_reg;
    logic [IDX_W-1:0]   s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               done_reg;
    logic [EIDX_W-1:0]  out_index_reg;
    logic [DIST_W-1:0]  out_dist_reg;

    // palette count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (count_we)
        begin
            count_reg <= count_wdata;
        end
    end

    // last index searched, count clamped to one..depth
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            last_next = '0;
        end
        else if (count_reg > DEPTH_C)
        begin
            last_next = IDX_W'(PALETTE_DEPTH - 1);
        end
        else
        begin
            last_next = IDX_W'(count_reg - COUNT_W'(1));
        end
    end

    // loads beyond the palette are dropped
    assign wr_en = ctl.load_entry && ({1'b0, entry_index} < DEPTH_C);

    npcm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(entry_index)),
        .wr_data (entry_color),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // scan address and query capture
    always_ff @(posedge clk)
    begin
        if (ctl.start_query)
        begin
            query_reg <= query_color;
            last_reg  <= last_next;
            addr_reg  <= '0;
        end
        else if (ctl.issue_read)
        begin
            addr_reg <= addr_reg + IDX_W'(1);
        end
    end

    assign sts.scan_last   = (addr_reg == last_reg);
    assign sts.result_done = done_reg;

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.issue_read;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg && s3_last_reg;
        end
    end

    // squares, distance sum and running minimum
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= addr_reg;
        s1_last_reg <= sts.scan_last;
        s2_idx_reg  <= s1_idx_reg;
        s2_last_reg <= s1_last_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_last_reg <= s2_last_reg;

        sq_r_reg <= chan_sq(query_reg[23:16], rd_data[23:16]);
        sq_g_reg <= chan_sq(query_reg[15:8],  rd_data[15:8]);
        sq_b_reg <= chan_sq(query_reg[7:0],   rd_data[7:0]);
        dist_reg <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

        // strict less-than keeps the lowest index on a tie
        if (s3_valid_reg && ((s3_idx_reg == '0) || (dist_reg < best_dist_reg)))
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= s3_idx_reg;
        end

        if (ctl.load_result)
        begin
            out_index_reg <= EIDX_W'(best_idx_reg);
            out_dist_reg  <= best_dist_reg;
        end
    end

    assign best_index    = out_index_reg;
    assign best_distance = out_dist_reg;

endmodule

// File: sv/npcm_checker.sv
`include "assert_macros.svh"

module npcm_checker import npcm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [CMD_W-1:0]  in_cmd,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DIST_W-1:0] out_dist
);

    // a query transfer closes the input until its result is out
    `ASSERT_NEXT(a_query_blocks, in_valid && in_ready && in_cmd == CMD_QUERY, !in_ready)

    // a load transfer never raises a result
    `ASSERT_NEXT(a_load_no_result, in_valid && in_ready && in_cmd == CMD_LOAD && !out_valid, !out_valid)

    // a result only appears at the end of a scan
    `ASSERT_SAME(a_result_after_scan, $rose(out_valid), $past(!in_ready))

    // result distance within the rgb888 range
    `ASSERT_SAME(a_dist_range, out_valid, out_dist <= MAX_DIST)

    // a stalled result stays offered
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

endmodule

bind nearest_palette_color_match_unit npcm_checker u_npcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_dist  (out_ch.best_distance)
);

// File: bench/testbench.sv
module testbench;
    import npcm_pkg::*;

    localparam int unsigned PAL_DEPTH    = 256;
    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 5;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned DRAIN_CYCLES = 270;
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned PHASE_ITEMS  = 220;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [EIDX_W-1:0]  entry_index;
        logic [COLOR_W-1:0] entry_color;
        logic [COLOR_W-1:0] query_color;
    } palette_item_t;

    typedef struct {
        logic [EIDX_W-1:0] best_index;
        logic [DIST_W-1:0] best_distance;
    } match_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               palette_count_we;
    logic [COUNT_W-1:0] palette_count_wdata;

    npcm_in_if  in_ch ();
    npcm_out_if out_ch ();

    nearest_palette_color_match_unit #(.PALETTE_DEPTH(PAL_DEPTH)) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_ch               (in_ch),
        .out_ch              (out_ch),
        .palette_count_we    (palette_count_we),
        .palette_count_wdata (palette_count_wdata)
    );

    // local copy of the palette and the search count
    logic [COLOR_W-1:0] palette_mem [PAL_DEPTH];
    logic [COUNT_W-1:0] search_count_cfg;
    match_t             pending_matches [$];

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // entries searched by a query: zero acts as one, saturate at depth
    function automatic int unsigned searched_entries();
        int unsigned n;
        n = 32'(search_count_cfg);
        if (n == 0)
            n = 1;
        if (n > PAL_DEPTH)
            n = PAL_DEPTH;
        return n;
    endfunction

    function automatic int unsigned color_distance(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
        int unsigned sum;
        int          d;
        sum = 0;
        for (int ch = 0; ch < 3; ch++)
        begin
            d = int'(a[ch*CHAN_W +: CHAN_W]) - int'(b[ch*CHAN_W +: CHAN_W]);
            sum += d * d;
        end
        return sum;
    endfunction

    // update the palette copy or queue the nearest-entry answer
    function automatic void apply_item(input palette_item_t it);
        match_t      m;
        int unsigned best_d;
        int unsigned d;
        int unsigned best_i;
        if (it.cmd == CMD_LOAD)
        begin
            if (it.entry_index < PAL_DEPTH)
                palette_mem[it.entry_index] = it.entry_color;
        end
        else
        begin
            best_i = 0;
            best_d = color_distance(it.query_color, palette_mem[0]);
            // strict less-than keeps the lowest index on a tie
            for (int unsigned i = 1; i < searched_entries(); i++)
            begin
                d = color_distance(it.query_color, palette_mem[i]);
                if (d < best_d)
                begin
                    best_d = d;
                    best_i = i;
                end
            end
            m.best_index    = best_i[EIDX_W-1:0];
            m.best_distance = best_d[DIST_W-1:0];
            pending_matches.insert(pending_matches.size(), m);
        end
    endfunction

    function automatic palette_item_t load_item(input logic [EIDX_W-1:0] slot,
                                                input logic [COLOR_W-1:0] color);
        palette_item_t it;
        it.cmd         = CMD_LOAD;
        it.entry_index = slot;
        it.entry_color = color;
        it.query_color = COLOR_W'($urandom);
        return it;
    endfunction

    function automatic palette_item_t query_item(input logic [COLOR_W-1:0] color);
        palette_item_t it;
        it.cmd         = CMD_QUERY;
        it.entry_index = EIDX_W'($urandom);
        it.entry_color = COLOR_W'($urandom);
        it.query_color = color;
        return it;
    endfunction

    // channel values biased toward the ends and the middle
    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CHAN_W'($urandom_range(8'h7E, 8'h81));
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        return {pick_channel(), pick_channel(), pick_channel()};
    endfunction

    // one input transfer, with random sender gaps
    task automatic send_item(input palette_item_t it);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= it.cmd;
        in_ch.entry_index <= it.entry_index;
        in_ch.entry_color <= it.entry_color;
        in_ch.query_color <= it.query_color;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        apply_item(it);
    endtask

    // hold off until every result is back and the block has settled
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_palette_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        palette_count_we    <= 1'b1;
        palette_count_wdata <= value;
        @(posedge clk);
        palette_count_we    <= 1'b0;
        search_count_cfg     = value;
        @(posedge clk);
    endtask

    // result receiver: check each transfer, then pick next ready
    always @(posedge clk)
    begin
        match_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result: best_index %0d best_distance %0d",
                       out_ch.best_index, out_ch.best_distance);
                mismatch_count++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (out_ch.best_index !== want.best_index)
                begin
                    $error("best_index mismatch: expected %0d, actual %0d",
                           want.best_index, out_ch.best_index);
                    mismatch_count++;
                end
                if (out_ch.best_distance !== want.best_distance)
                begin
                    $error("best_distance mismatch: expected %0d, actual %0d",
                           want.best_distance, out_ch.best_distance);
                    mismatch_count++;
                end
            end
        end
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // reset count of one searches only entry zero
    task automatic test_reset_count();
        send_item(load_item(8'd0, 24'h000000));
        send_item(query_item(24'h000000));
        send_item(query_item(24'hFFFFFF));
        send_item(load_item(8'd0, 24'hFFFFFF));
        send_item(query_item(24'h000000));
    endtask

    // extreme colors and duplicate entries for the tie rule
    task automatic test_extremes_and_ties();
        send_item(load_item(8'd1, 24'h000000));
        send_item(load_item(8'd2, 24'h000000));
        send_item(load_item(8'd3, 24'h808080));
        send_item(load_item(8'd4, 24'hFF0000));
        send_item(load_item(8'd5, 24'h7F7F7F));
        write_palette_count(9'd6);
        send_item(query_item(24'h000000));
        send_item(query_item(24'h808080));
        send_item(query_item(24'hC0C0C0));
        send_item(query_item(24'hFF0000));
        send_item(query_item(24'h0000FF));
        send_item(query_item(24'hFF00FF));
        send_item(query_item(24'h00FFFF));
    endtask

    // count of zero, full depth and counts above depth
    task automatic test_count_limits();
        write_palette_count(9'd0);
        send_item(query_item(24'h000000));
        // every slot written before any wide search
        for (int unsigned i = 0; i < PAL_DEPTH; i++)
            send_item(load_item(i[7:0], {i[7:0], ~i[7:0], i[7:0] ^ 8'h5A}));
        send_item(load_item(8'd255, 24'h123456));
        write_palette_count(9'd256);
        send_item(query_item(24'h123456));
        write_palette_count(9'd511);
        send_item(query_item(24'h123457));
        write_palette_count(9'd257);
        send_item(query_item(24'hFFFFFF));
    endtask

    // random loads and queries in chunks, new search count per chunk
    task automatic test_random_phase(input int unsigned gap_pct,
                                     input int unsigned stall_pct);
        int unsigned       sent;
        int unsigned       chunk;
        logic [COUNT_W-1:0] cnt;
        logic [COLOR_W-1:0] color;
        logic [EIDX_W-1:0]  slot;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       cnt = 9'd256;
                1:       cnt = COUNT_W'($urandom_range(257, 511));
                2:       cnt = 9'd0;
                3:       cnt = 9'd1;
                4:       cnt = COUNT_W'($urandom_range(25, 255));
                default: cnt = COUNT_W'($urandom_range(2, 24));
            endcase
            write_palette_count(cnt);
            chunk = $urandom_range(20, 60);
            for (int unsigned k = 0; k < chunk; k++)
            begin
                if ($urandom_range(0, 99) < 45)
                begin
                    if ($urandom_range(0, 9) < 7)
                        slot = EIDX_W'($urandom_range(0, searched_entries() - 1));
                    else
                        slot = EIDX_W'($urandom);
                    case ($urandom_range(0, 2))
                        0:       color = COLOR_W'($urandom);
                        1:       color = palette_mem[$urandom_range(0, PAL_DEPTH - 1)];
                        default: color = pick_color();
                    endcase
                    send_item(load_item(slot, color));
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: color = palette_mem[$urandom_range(0, searched_entries() - 1)];
                        1: color = pick_color();
                        2: color = COLOR_W'($urandom);
                        default:
                        begin
                            color = palette_mem[$urandom_range(0, searched_entries() - 1)];
                            color[$urandom_range(0, COLOR_W - 1)] ^= 1'b1;
                        end
                    endcase
                    send_item(query_item(color));
                end
            end
            sent += chunk;
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.cmd           <= CMD_LOAD;
        in_ch.entry_index   <= '0;
        in_ch.entry_color   <= '0;
        in_ch.query_color   <= '0;
        palette_count_we    <= 1'b0;
        palette_count_wdata <= '0;
        send_gap_pct         = 0;
        recv_stall_pct       = 0;
        search_count_cfg     = COUNT_RESET;
        for (int unsigned i = 0; i < PAL_DEPTH; i++)
            palette_mem[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_extremes_and_ties();
        test_count_limits();
        test_random_phase(0, 0);
        test_random_phase(65, 0);
        test_random_phase(0, 65);
        test_random_phase(26, 26);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_matches.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
